[rtl/core/udim_pkg.sv]
// ----------------------------------------------------------------------------
// udim_pkg
// Shared types and codes for the device ID table match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package udim_pkg;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_MATCH_INTF = 2'd1,
    OP_MATCH_DEV  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // match flag bit positions
  localparam int FLAG_VENDOR  = 0;
  localparam int FLAG_PRODUCT = 1;
  localparam int FLAG_REL_LO  = 2;
  localparam int FLAG_REL_HI  = 3;
  localparam int FLAG_DCLASS  = 4;
  localparam int FLAG_DSUB    = 5;
  localparam int FLAG_DPROTO  = 6;
  localparam int FLAG_ICLASS  = 7;
  localparam int FLAG_ISUB    = 8;
  localparam int FLAG_IPROTO  = 9;
  localparam int FLAG_INUM    = 10;

  localparam logic [7:0] CLASS_VENDOR_SPEC = 8'hFF;

  typedef struct packed {
    logic [10:0] flags;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] rel_lo;
    logic [15:0] rel_hi;
    logic [23:0] dclass;
    logic [31:0] intf;
  } entry_t;

  typedef struct packed {
    logic        intf_mode;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] release_num;
    logic [23:0] dclass;
    logic [31:0] intf;
  } query_t;

  typedef struct packed {
    logic term;
    logic hit;
  } match_res_t;

endpackage

`default_nettype wire

[rtl/core/udim_table.sv]
// ----------------------------------------------------------------------------
// udim_table
// Entry store: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module udim_table import udim_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_entry
);

  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  entry_t                 rd_data;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // an entry never written reads as all zero, i.e. a terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd_entry = rd_vld ? rd_data : '0;

endmodule

`default_nettype wire

[rtl/core/udim_match.sv]
// ----------------------------------------------------------------------------
// udim_match
// Compares one table entry against the held query: terminator and hit.
// ----------------------------------------------------------------------------
`default_nettype none

module udim_match import udim_pkg::*; (
  input  wire entry_t     entry,
  input  wire query_t     query,
  output match_res_t      res
);

  logic [10:0] f;
  logic        dev_ok;
  logic        intf_ok;
  logic        key_zero;

  assign f = entry.flags;

  always_comb begin
    dev_ok = 1'b1;
    if (f[FLAG_VENDOR]  && entry.vendor  != query.vendor)  dev_ok = 1'b0;
    if (f[FLAG_PRODUCT] && entry.product != query.product) dev_ok = 1'b0;
    if (f[FLAG_REL_LO]  && entry.rel_lo > query.release_num) dev_ok = 1'b0;
    if (f[FLAG_REL_HI]  && entry.rel_hi < query.release_num) dev_ok = 1'b0;
    if (f[FLAG_DCLASS]  && entry.dclass[23:16] != query.dclass[23:16]) dev_ok = 1'b0;
    if (f[FLAG_DSUB]    && entry.dclass[15:8]  != query.dclass[15:8])  dev_ok = 1'b0;
    if (f[FLAG_DPROTO]  && entry.dclass[7:0]   != query.dclass[7:0])   dev_ok = 1'b0;
  end

  always_comb begin
    intf_ok = 1'b1;
    // vendor-specific device: interface-only entries must not bind
    if (query.dclass[23:16] == CLASS_VENDOR_SPEC && !f[FLAG_VENDOR] &&
        (f[FLAG_ICLASS] || f[FLAG_ISUB] || f[FLAG_IPROTO] || f[FLAG_INUM])) begin
      intf_ok = 1'b0;
    end
    if (f[FLAG_ICLASS] && entry.intf[31:24] != query.intf[31:24]) intf_ok = 1'b0;
    if (f[FLAG_ISUB]   && entry.intf[23:16] != query.intf[23:16]) intf_ok = 1'b0;
    if (f[FLAG_IPROTO] && entry.intf[15:8]  != query.intf[15:8])  intf_ok = 1'b0;
    if (f[FLAG_INUM]   && entry.intf[7:0]   != query.intf[7:0])   intf_ok = 1'b0;
  end

  assign key_zero = (entry.vendor == 16'd0) && (entry.product == 16'd0);

  always_comb begin
    if (query.intf_mode) begin
      res.term = key_zero && (entry.dclass[23:16] == 8'd0) && (entry.intf[31:24] == 8'd0);
      res.hit  = dev_ok && intf_ok;
    end else begin
      res.term = key_zero;
      res.hit  = dev_ok;
    end
  end

endmodule

`default_nettype wire

[rtl/core/udim_ctrl.sv]
// ----------------------------------------------------------------------------
// udim_ctrl
// Sequencer: takes beats, drives table writes and the scan, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module udim_ctrl import udim_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       operation,
  input  wire logic [3:0]       entry_index,
  input  wire logic [15:0]      vendor_id,
  input  wire logic [15:0]      product_id,
  input  wire logic [15:0]      release_or_low,
  input  wire logic [23:0]      device_class_fields,
  input  wire logic [31:0]      interface_fields,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  matched,
  output logic [3:0]            match_index,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [IDX_W-1:0]      rd_addr,
  output query_t                query,
  input  wire match_res_t       res
);

  state_t           state, state_next;
  op_t              op;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic             res_found, res_found_next;
  logic [IDX_W-1:0] res_idx, res_idx_next;
  query_t           query_next;
  logic             out_load;
  logic             last;
  logic             in_range;

  assign op       = op_t'(operation);
  assign in_range = int'(entry_index) < TABLE_DEPTH;
  assign wr_addr  = IDX_W'(entry_index);
  assign last     = cur_idx == IDX_W'(TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    wr_en          = 1'b0;
    rd_addr        = '0;
    cur_idx_next   = cur_idx;
    res_found_next = res_found;
    res_idx_next   = res_idx;
    query_next     = query;
    out_load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        // entry 0 is read on every idle cycle so a scan starts straight away
        rd_addr  = '0;
        if (in_valid) begin
          query_next = '{intf_mode:   (op == OP_MATCH_INTF),
                         vendor:      vendor_id,
                         product:     product_id,
                         release_num: release_or_low,
                         dclass:      device_class_fields,
                         intf:        interface_fields};
          res_found_next = 1'b0;
          res_idx_next   = '0;
          cur_idx_next   = '0;
          unique case (op) inside
            OP_WRITE: begin
              wr_en      = in_range;
              state_next = S_EMIT;
            end
            OP_MATCH_INTF, OP_MATCH_DEV: begin
              state_next = S_SCAN;
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = last ? '0 : IDX_W'(cur_idx + 1'b1);
        if (res.term) begin
          state_next = S_EMIT;
        end else if (res.hit) begin
          res_found_next = 1'b1;
          res_idx_next   = cur_idx;
          state_next     = S_EMIT;
        end else if (last) begin
          state_next = S_EMIT;
        end else begin
          cur_idx_next = IDX_W'(cur_idx + 1'b1);
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_idx   <= cur_idx_next;
    res_found <= res_found_next;
    res_idx   <= res_idx_next;
    query     <= query_next;
  end

  // output register frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      matched     <= res_found;
      match_index <= 4'(res_idx);
    end
  end

endmodule

`default_nettype wire

[rtl/core/usb_device_id_table_match_unit.sv]
// ----------------------------------------------------------------------------
// usb_device_id_table_match_unit
// Device ID table with first-match lookup from entry 0.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat is a table write (operation 0),
// an interface-mode query (1) or a device-only query (2). Every beat gives
// exactly one beat on the output channel (out_valid / out_stall) carrying
// matched and match_index; writes and unused codes return zeros.
// A write or unused code passes through the emit state to the output register.
// A query reads one entry per cycle from the table's read port and decides on
// it the cycle after the read, up to the last entry. One beat is worked on at
// a time; in_stall is high from acceptance until the result moves into the
// output register.
// The output register holds a result while out_stall is high; the next input
// beat is still taken, and its result waits in the sequencer until the output
// register is free.
// Reset clears the per-entry valid bits, so the whole table reads as zero (a
// terminator at entry 0) with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_device_id_table_match_unit import udim_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [3:0]  entry_index,
  input  wire logic [10:0] key_flags,
  input  wire logic [15:0] vendor_id,
  input  wire logic [15:0] product_id,
  input  wire logic [15:0] release_or_low,
  input  wire logic [15:0] release_high,
  input  wire logic [23:0] device_class_fields,
  input  wire logic [31:0] interface_fields,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             matched,
  output logic [3:0]       match_index
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           wr_data;
  entry_t           rd_entry;
  query_t           query;
  match_res_t       res;

  assign wr_data = '{flags:   key_flags,
                     vendor:  vendor_id,
                     product: product_id,
                     rel_lo:  release_or_low,
                     rel_hi:  release_high,
                     dclass:  device_class_fields,
                     intf:    interface_fields};

  udim_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  udim_match u_match (
    .entry (rd_entry),
    .query (query),
    .res   (res)
  );

  udim_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .operation           (operation),
    .entry_index         (entry_index),
    .vendor_id           (vendor_id),
    .product_id          (product_id),
    .release_or_low      (release_or_low),
    .device_class_fields (device_class_fields),
    .interface_fields    (interface_fields),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .matched             (matched),
    .match_index         (match_index),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .rd_addr             (rd_addr),
    .query               (query),
    .res                 (res)
  );

endmodule

`default_nettype wire

[rtl/core/udim_checker.sv]
// ----------------------------------------------------------------------------
// udim_checker
// Port-level checks on the match unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module udim_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       matched,
  input wire logic [3:0] match_index
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched) && $stable(match_index))
    else $error("output beat changed while stalled");

  // no-match results always carry index zero
  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> match_index == 4'd0)
    else $error("non-zero index on a miss");

  // one beat in flight: the input closes right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind usb_device_id_table_match_unit udim_checker u_udim_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .matched     (matched),
  .match_index (match_index)
);

`default_nettype wire
